// ===== sv/ole_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ordered list engine: sizes, request codes and the command type.
// It depends on nothing; every module of the block imports it.
package ole_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int REQ_W       = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [REQ_W-1:0] REQ_FRONT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BACK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd3;

    typedef enum logic [1:0] {
        OP_INS_FRONT,
        OP_INS_BACK,
        OP_REMOVE,
        OP_FIND
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

// ===== sv/ole_front.sv =====
`timescale 1ns / 1ps
// Front end of the ordered list engine: accepts requests, decodes them into commands
// and holds them in a two-entry queue for the back end. Depends on ole_pkg.
module ole_front
    import ole_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic signed [VALUE_W-1:0]  s_tdata,
    input  logic [REQ_W-1:0]           s_tuser,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output cmd_t                       cmd
);

    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    cmd_t       slot_reg [2];
    cmd_t       decoded;
    logic       push;
    logic       pop;

    always_comb
    begin
        unique case (s_tuser)
            REQ_FRONT:  decoded.op = OP_INS_FRONT;
            REQ_BACK:   decoded.op = OP_INS_BACK;
            REQ_REMOVE: decoded.op = OP_REMOVE;
            REQ_FIND:   decoded.op = OP_FIND;
            default:    decoded.op = OP_FIND;
        endcase
        decoded.value = s_tdata;
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        fill_next   = fill_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== sv/ole_back.sv =====
`timescale 1ns / 1ps
// Back end of the ordered list engine: a row of cells with per-cell compare and shift,
// the entry count and the result register. Depends on ole_pkg.
module ole_back
    import ole_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  cmd_t                    cmd,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata
);

    logic signed [VALUE_W-1:0] cell_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic                      rejected_reg;
    logic                      rejected_next;
    logic [CAPACITY-1:0]       match;
    logic [CAPACITY-1:0]       at_or_after;
    logic                      seen;
    logic                      any_match;
    logic                      full;
    logic                      fire;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign cmd_ready = !out_valid_reg || m_tready;
    assign fire      = cmd_valid && cmd_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        seen = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i]       = (CNT_W'(i) < count_reg) && (cell_reg[i] == cmd.value);
            seen           = seen || match[i];
            at_or_after[i] = seen;
        end
        any_match = seen;
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        count_next     = count_reg;
        hit_next       = hit_reg;
        rejected_next  = rejected_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            hit_next       = 1'b0;
            rejected_next  = 1'b0;
            unique case (cmd.op)
                OP_INS_FRONT:
                begin
                    if (full)
                    begin
                        rejected_next = 1'b1;
                    end
                    else
                    begin
                        cell_next[0] = cmd.value;
                        for (int i = 1; i < CAPACITY; i++)
                        begin
                            cell_next[i] = cell_reg[i-1];
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_INS_BACK:
                begin
                    if (full)
                    begin
                        rejected_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (CNT_W'(i) == count_reg)
                            begin
                                cell_next[i] = cmd.value;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    hit_next = any_match;
                    if (any_match)
                    begin
                        for (int i = 0; i < CAPACITY - 1; i++)
                        begin
                            if (at_or_after[i])
                            begin
                                cell_next[i] = cell_reg[i+1];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_FIND:
                begin
                    hit_next = any_match;
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        hit_reg      <= hit_next;
        rejected_reg <= rejected_next;
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, count_ext[COUNT_OUT_W-1:0], rejected_reg, hit_reg};

endmodule

// ===== sv/ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
// Top level of the ordered list engine: front end queue and back end cell row.
// Depends on ole_pkg, ole_front and ole_back.
//
//   Channel  Direction  Contents
//   s_*      in         request: tuser = req_type, tdata = value
//   m_*      out        result: tdata = hit, rejected, entry_count, zero pad
//
// The cell row takes one request per cycle as long as each result is taken without a stall.
// A request passes through a queue slot, then the result register, on its way to the result.
// Reset clears the entry count and the queue; the cells themselves are not cleared.
// A stalled result holds the cell row; the two-entry queue keeps taking requests until full.
module ordered_list_engine_top
    import ole_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic signed [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic [REQ_W-1:0]          s_tuser,   // [1:0] req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata    // [0] hit, [1] rejected, [6:2] entry_count
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    ole_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ole_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== bench/tb_ordered_list_engine_top.sv =====
`timescale 1ns / 1ps
// Testbench for ordered_list_engine_top: directed and random list requests checked
// against a local list predictor. Depends on ole_pkg and ordered_list_engine_top.
module tb_ordered_list_engine_top;
    import ole_pkg::*;

    localparam int LIMIT        = 200000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASE_LEN    = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_LEN     = 60;
    localparam int DRAIN        = 10;

    typedef struct packed {
        logic [REQ_W-1:0]          kind;
        logic signed [VALUE_W-1:0] value;
    } list_req_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] count;
        logic                   rejected;
        logic                   hit;
    } list_reply_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic signed [VALUE_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0]          s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [7:0]                m_tdata;

    list_req_t                 req_backlog[$];
    list_reply_t               replies_due[$];
    logic signed [VALUE_W-1:0] list_cells[CAPACITY];
    logic signed [VALUE_W-1:0] value_pool[6];
    int                        list_len = 0;
    int                        sent_cnt = 0;
    int                        cycles = 0;
    int                        mismatches = 0;
    int                        hold_left = 0;
    logic                      hold_done = 1'b0;
    int                        send_idle_pct;
    int                        stall_pct;

    ordered_list_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    always_comb
    begin
        case ((sent_cnt / PHASE_LEN) % 4)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 73;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 73;
            end
            default:
            begin
                send_idle_pct = 13;
                stall_pct = 13;
            end
        endcase
    end

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic signed [VALUE_W-1:0] val);
        list_req_t r;
        r.kind = kind;
        r.value = val;
        req_backlog.push_back(r);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: return 32'sh8000_0000;
            3: return 32'sh7FFF_FFFF;
            default: return value_pool[$urandom_range(5)];
        endcase
    endfunction

    task automatic apply_list_request(input logic [REQ_W-1:0] kind,
                                      input logic signed [VALUE_W-1:0] val);
        list_reply_t r;
        int pos;
        int i;
        r = '0;
        pos = -1;
        if (kind == REQ_FRONT || kind == REQ_BACK)
        begin
            if (list_len >= CAPACITY)
            begin
                r.rejected = 1'b1;
            end
            else if (kind == REQ_FRONT)
            begin
                for (i = list_len; i > 0; i--)
                begin
                    list_cells[i] = list_cells[i-1];
                end
                list_cells[0] = val;
                list_len++;
            end
            else
            begin
                list_cells[list_len] = val;
                list_len++;
            end
        end
        else
        begin
            for (i = 0; i < list_len; i++)
            begin
                if (pos < 0 && list_cells[i] == val)
                begin
                    pos = i;
                end
            end
            if (pos >= 0)
            begin
                r.hit = 1'b1;
                if (kind == REQ_REMOVE)
                begin
                    for (i = pos; i < list_len - 1; i++)
                    begin
                        list_cells[i] = list_cells[i+1];
                    end
                    list_len--;
                end
            end
        end
        r.count = COUNT_OUT_W'(list_len);
        replies_due.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        list_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                apply_list_request(s_tuser, s_tdata);
                sent_cnt <= sent_cnt + 1;
            end
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = req_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= nxt.kind;
                s_tdata <= nxt.value;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && sent_cnt >= HOLD_AT)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : reply_check
        list_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, actual 0x%02h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("hit", want.hit, m_tdata[0]);
                check_field("rejected", want.rejected, m_tdata[1]);
                check_field("entry_count", want.count, m_tdata[6:2]);
                check_field("pad", 0, m_tdata[7]);
            end
        end
    end

    initial
    begin
        int made;
        int chunk_len;
        int ins_pct;
        int k;
        logic [REQ_W-1:0] kind;

        push_req(REQ_FIND, 32'sd7);
        push_req(REQ_REMOVE, 32'sd7);
        push_req(REQ_FRONT, 32'sh8000_0000);
        push_req(REQ_BACK, 32'sh7FFF_FFFF);
        push_req(REQ_FRONT, -32'sd1);
        push_req(REQ_BACK, 32'sd0);
        push_req(REQ_BACK, -32'sd1);
        push_req(REQ_FIND, -32'sd1);
        push_req(REQ_REMOVE, -32'sd1);
        push_req(REQ_FIND, 32'sd5);
        push_req(REQ_REMOVE, 32'sd5);
        for (k = 0; k < 12; k++)
        begin
            push_req(k[0] ? REQ_FRONT : REQ_BACK, k[1] ? 32'sh5555_5555 : 32'shAAAA_AAAA);
        end
        push_req(REQ_FRONT, 32'sd1);
        push_req(REQ_BACK, 32'sd1);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            value_pool[0] = 32'sd0;
            value_pool[1] = -32'sd1;
            for (k = 2; k < 6; k++)
            begin
                value_pool[k] = $urandom;
            end
            case ($urandom_range(2))
                0: ins_pct = 85;
                1: ins_pct = 50;
                default: ins_pct = 20;
            endcase
            chunk_len = $urandom_range(20, 80);
            for (k = 0; k < chunk_len; k++)
            begin
                if ($urandom_range(99) < ins_pct)
                begin
                    kind = $urandom_range(1) ? REQ_FRONT : REQ_BACK;
                end
                else
                begin
                    kind = $urandom_range(1) ? REQ_REMOVE : REQ_FIND;
                end
                push_req(kind, pick_value());
            end
            made += chunk_len;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while ((req_backlog.size() > 0 || s_tvalid || replies_due.size() > 0) && cycles < LIMIT)
        begin
            @(posedge clk);
        end
        if (cycles >= LIMIT)
        begin
            $display("simulation failed");
        end
        else
        begin
            repeat (DRAIN) @(posedge clk);
            if (replies_due.size() > 0)
            begin
                $display("%0t: %0d replies expected but never seen", $time, replies_due.size());
                mismatches++;
            end
            if (mismatches == 0)
            begin
                $display("simulation ok");
            end
            else
            begin
                $display("simulation failed");
            end
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ole_pkg.sv
sv/ole_front.sv
sv/ole_back.sv
sv/ordered_list_engine_top.sv
bench/tb_ordered_list_engine_top.sv
